>>> src/packet_fifo_dedup_count_core_defines.svh
// Assertion macros shared by the packet FIFO core.
// No dependencies; included by the top level only.
`ifndef PACKET_FIFO_DEDUP_COUNT_CORE_DEFINES_SVH
`define PACKET_FIFO_DEDUP_COUNT_CORE_DEFINES_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define PFDC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a condition never holds.
`define PFDC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> src/pfdc_pkg.sv
// Shared types and constants of the packet FIFO core.
// No dependencies.
package pfdc_pkg;

	localparam int unsigned DepthDefault    = 256;
	localparam int unsigned IdBitsDefault   = 16;
	localparam int unsigned TimeBitsDefault = 32;
	localparam int unsigned LimitBits       = 9;
	localparam int unsigned CountBits       = 9;
	localparam logic [LimitBits-1:0] LimitReset = 9'd256;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_FWD = 2'd1,
		OP_CNT = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef struct packed {
		logic idle;
		logic finishing;
	} back_status_t;

endpackage

>>> src/pfdc_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module pfdc_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/pfdc_front.sv
// Front end: accepts requests, decodes the command and buffers them in a two entry queue.
// Depends on pfdc_pkg.
module pfdc_front #(
	parameter int unsigned ID_BITS   = pfdc_pkg::IdBitsDefault,
	parameter int unsigned TIME_BITS = pfdc_pkg::TimeBitsDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           command,
	input  logic [ID_BITS-1:0]   source,
	input  logic [ID_BITS-1:0]   destination,
	input  logic [TIME_BITS-1:0] timestamp,
	input  logic [TIME_BITS-1:0] range_start,
	input  logic [TIME_BITS-1:0] range_end,
	output logic                 q_valid,
	input  logic                 q_ready,
	output pfdc_pkg::op_t        q_op,
	output logic                 q_range_empty,
	output logic [ID_BITS-1:0]   q_source,
	output logic [ID_BITS-1:0]   q_destination,
	output logic [TIME_BITS-1:0] q_timestamp,
	output logic [TIME_BITS-1:0] q_range_start,
	output logic [TIME_BITS-1:0] q_range_end
);
	import pfdc_pkg::*;

	op_t                  op_q    [2];
	logic                 empty_q [2];
	logic [ID_BITS-1:0]   src_q   [2];
	logic [ID_BITS-1:0]   dst_q   [2];
	logic [TIME_BITS-1:0] ts_q    [2];
	logic [TIME_BITS-1:0] lo_q    [2];
	logic [TIME_BITS-1:0] hi_q    [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 push;
	logic                 pop;
	op_t                  op_dec;

	always_comb begin
		case (command)
			OP_ADD:  op_dec = OP_ADD;
			OP_FWD:  op_dec = OP_FWD;
			OP_CNT:  op_dec = OP_CNT;
			default: op_dec = OP_NOP;
		endcase
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_valid && q_ready;

	assign q_op          = op_q[rd_ptr_q];
	assign q_range_empty = empty_q[rd_ptr_q];
	assign q_source      = src_q[rd_ptr_q];
	assign q_destination = dst_q[rd_ptr_q];
	assign q_timestamp   = ts_q[rd_ptr_q];
	assign q_range_start = lo_q[rd_ptr_q];
	assign q_range_end   = hi_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]    <= op_dec;
			empty_q[wr_ptr_q] <= (range_start > range_end);
			src_q[wr_ptr_q]   <= source;
			dst_q[wr_ptr_q]   <= destination;
			ts_q[wr_ptr_q]    <= timestamp;
			lo_q[wr_ptr_q]    <= range_start;
			hi_q[wr_ptr_q]    <= range_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> src/pfdc_back.sv
// Back end: walks the held packets in the RAM, applies the request and registers the result.
// Depends on pfdc_pkg and pfdc_ram.
module pfdc_back #(
	parameter int unsigned DEPTH     = pfdc_pkg::DepthDefault,
	parameter int unsigned ID_BITS   = pfdc_pkg::IdBitsDefault,
	parameter int unsigned TIME_BITS = pfdc_pkg::TimeBitsDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [pfdc_pkg::LimitBits-1:0] memory_limit,
	input  logic                           q_valid,
	output logic                           q_ready,
	input  pfdc_pkg::op_t                  q_op,
	input  logic                           q_range_empty,
	input  logic [ID_BITS-1:0]             q_source,
	input  logic [ID_BITS-1:0]             q_destination,
	input  logic [TIME_BITS-1:0]           q_timestamp,
	input  logic [TIME_BITS-1:0]           q_range_start,
	input  logic [TIME_BITS-1:0]           q_range_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           ok,
	output logic [ID_BITS-1:0]             out_source,
	output logic [ID_BITS-1:0]             out_destination,
	output logic [TIME_BITS-1:0]           out_timestamp,
	output logic [pfdc_pkg::CountBits-1:0] match_count,
	output pfdc_pkg::back_status_t         status
);
	import pfdc_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FW = $clog2(DEPTH + 1);
	localparam int unsigned LW = (FW > LimitBits) ? FW : LimitBits;
	localparam int unsigned SW = FW + 1;
	localparam int unsigned RW = 2 * ID_BITS + TIME_BITS;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t               state_q;
	op_t                  op_q;
	logic [ID_BITS-1:0]   src_q;
	logic [ID_BITS-1:0]   dst_q;
	logic [TIME_BITS-1:0] ts_q;
	logic [TIME_BITS-1:0] lo_q;
	logic [TIME_BITS-1:0] hi_q;
	logic [AW-1:0]        head_q;
	logic [FW-1:0]        fill_q;
	logic [AW-1:0]        rd_ptr_q;
	logic [FW-1:0]        rem_q;
	logic                 rd_valid_s1;
	logic                 hit_q;
	logic [CountBits-1:0] cnt_q;

	logic                 re;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [RW-1:0]        rdata;
	logic [ID_BITS-1:0]   rd_src;
	logic [ID_BITS-1:0]   rd_dst;
	logic [TIME_BITS-1:0] rd_ts;
	logic                 fin_go;
	logic [LW-1:0]        lim_ext;
	logic [LW-1:0]        lim_eff;
	logic                 drop;
	logic [AW-1:0]        head_new;
	logic [FW-1:0]        fill_new;
	logic [SW-1:0]        wsum;
	logic                 res_ok;
	logic [ID_BITS-1:0]   res_src;
	logic [ID_BITS-1:0]   res_dst;
	logic [TIME_BITS-1:0] res_ts;
	logic [CountBits-1:0] res_cnt;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (AW'(DEPTH - 1) == p) begin
			r = '0;
		end else begin
			r = p + AW'(1);
		end
		return r;
	endfunction

	assign rd_src = rdata[RW-1 -: ID_BITS];
	assign rd_dst = rdata[TIME_BITS +: ID_BITS];
	assign rd_ts  = rdata[TIME_BITS-1:0];

	assign q_ready = (state_q == ST_IDLE);
	assign re      = (state_q == ST_SCAN) && (rem_q != '0);
	assign fin_go  = (state_q == ST_FIN) && (!out_valid || out_ready);

	// Effective capacity: zero behaves as one, anything above the depth as the depth.
	always_comb begin
		lim_ext = LW'(memory_limit);
		if (lim_ext == '0) begin
			lim_eff = LW'(1);
		end else if (lim_ext > LW'(DEPTH)) begin
			lim_eff = LW'(DEPTH);
		end else begin
			lim_eff = lim_ext;
		end
		drop     = (LW'(fill_q) >= lim_eff) && (fill_q != '0);
		head_new = drop ? next_slot(head_q) : head_q;
		fill_new = drop ? (fill_q - FW'(1)) : fill_q;
		wsum     = SW'(head_new) + SW'(fill_new);
		if (wsum >= SW'(DEPTH)) begin
			wsum = wsum - SW'(DEPTH);
		end
		waddr = wsum[AW-1:0];
	end

	// Result of the request in the finishing step; fields without meaning stay zero.
	always_comb begin
		res_ok  = 1'b0;
		res_src = '0;
		res_dst = '0;
		res_ts  = '0;
		res_cnt = '0;
		case (op_q)
			OP_ADD: begin
				res_ok = !hit_q;
			end
			OP_FWD: begin
				if (fill_q != '0) begin
					res_ok  = 1'b1;
					res_src = rd_src;
					res_dst = rd_dst;
					res_ts  = rd_ts;
				end
			end
			OP_CNT: begin
				res_cnt = cnt_q;
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
	end

	assign we = fin_go && (op_q == OP_ADD) && !hit_q;

	pfdc_ram #(
		.WIDTH(RW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata({src_q, dst_q, ts_q}),
		.re   (re),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

	assign status.idle      = (state_q == ST_IDLE);
	assign status.finishing = (state_q == ST_FIN);

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			op_q  <= q_op;
			src_q <= q_source;
			dst_q <= q_destination;
			ts_q  <= q_timestamp;
			lo_q  <= q_range_start;
			hi_q  <= q_range_end;
		end
		if (fin_go) begin
			ok              <= res_ok;
			out_source      <= res_src;
			out_destination <= res_dst;
			out_timestamp   <= res_ts;
			match_count     <= res_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			rd_ptr_q    <= '0;
			rem_q       <= '0;
			rd_valid_s1 <= 1'b0;
			hit_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid   <= 1'b0;
		end else begin
			rd_valid_s1 <= re;
			if (fin_go) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						rd_ptr_q <= head_q;
						hit_q    <= 1'b0;
						cnt_q    <= '0;
						case (q_op)
							OP_ADD:  rem_q <= fill_q;
							OP_FWD:  rem_q <= (fill_q != '0) ? FW'(1) : '0;
							OP_CNT:  rem_q <= q_range_empty ? '0 : fill_q;
							default: rem_q <= '0;
						endcase
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (re) begin
						rd_ptr_q <= next_slot(rd_ptr_q);
						rem_q    <= rem_q - FW'(1);
					end
					if (rd_valid_s1) begin
						if (op_q == OP_ADD && rd_src == src_q && rd_dst == dst_q &&
							rd_ts == ts_q) begin
							hit_q <= 1'b1;
						end
						if (op_q == OP_CNT && rd_dst == dst_q && rd_ts >= lo_q &&
							rd_ts <= hi_q && cnt_q != '1) begin
							cnt_q <= cnt_q + CountBits'(1);
						end
					end
					if (rem_q == '0 && !rd_valid_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						if (op_q == OP_ADD && !hit_q) begin
							head_q <= head_new;
							fill_q <= fill_new + FW'(1);
						end else if (op_q == OP_FWD && fill_q != '0) begin
							head_q <= next_slot(head_q);
							fill_q <= fill_q - FW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/packet_fifo_dedup_count_core.sv
// The back end reads every held slot for an add or a count, the head slot for a forward of a
// held packet, and no slot for an unknown command, an empty forward, an empty range or an
// empty queue; it reads one RAM slot a cycle.
// The back end takes one request at a time; a two entry queue in front and the result
// register decouple stalls.
// Reset: asynchronous, active low; the queue comes up empty and memory_limit reads 256.
// Packet storage is not cleared; only slots inside the fill are ever read.
`include "packet_fifo_dedup_count_core_defines.svh"
module packet_fifo_dedup_count_core #(
	parameter int unsigned DEPTH     = pfdc_pkg::DepthDefault,
	parameter int unsigned ID_BITS   = pfdc_pkg::IdBitsDefault,
	parameter int unsigned TIME_BITS = pfdc_pkg::TimeBitsDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pfdc_pkg::LimitBits-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     command,
	input  logic [ID_BITS-1:0]             source,
	input  logic [ID_BITS-1:0]             destination,
	input  logic [TIME_BITS-1:0]           timestamp,
	input  logic [TIME_BITS-1:0]           range_start,
	input  logic [TIME_BITS-1:0]           range_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           ok,
	output logic [ID_BITS-1:0]             out_source,
	output logic [ID_BITS-1:0]             out_destination,
	output logic [TIME_BITS-1:0]           out_timestamp,
	output logic [pfdc_pkg::CountBits-1:0] match_count
);
	import pfdc_pkg::*;

	// The capacity register; the user must write it only while no request is in flight, as the block does not enforce it.
	logic [LimitBits-1:0] memory_limit_q;

	// Queue between the front end and the back end.
	logic                 q_valid;
	logic                 q_ready;
	op_t                  q_op;
	logic                 q_range_empty;
	logic [ID_BITS-1:0]   q_source;
	logic [ID_BITS-1:0]   q_destination;
	logic [TIME_BITS-1:0] q_timestamp;
	logic [TIME_BITS-1:0] q_range_start;
	logic [TIME_BITS-1:0] q_range_end;
	back_status_t         back_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			memory_limit_q <= LimitReset;
		end else if (cfg_we) begin
			memory_limit_q <= cfg_wdata;
		end
	end

	// The front end decodes each request and buffers up to two of them.
	pfdc_front #(
		.ID_BITS  (ID_BITS),
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.source       (source),
		.destination  (destination),
		.timestamp    (timestamp),
		.range_start  (range_start),
		.range_end    (range_end),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_op         (q_op),
		.q_range_empty(q_range_empty),
		.q_source     (q_source),
		.q_destination(q_destination),
		.q_timestamp  (q_timestamp),
		.q_range_start(q_range_start),
		.q_range_end  (q_range_end)
	);

	// The back end owns the packet RAM, the head pointer and the fill level, and
	// drives the result register directly.
	pfdc_back #(
		.DEPTH    (DEPTH),
		.ID_BITS  (ID_BITS),
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.memory_limit   (memory_limit_q),
		.q_valid        (q_valid),
		.q_ready        (q_ready),
		.q_op           (q_op),
		.q_range_empty  (q_range_empty),
		.q_source       (q_source),
		.q_destination  (q_destination),
		.q_timestamp    (q_timestamp),
		.q_range_start  (q_range_start),
		.q_range_end    (q_range_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ok             (ok),
		.out_source     (out_source),
		.out_destination(out_destination),
		.out_timestamp  (out_timestamp),
		.match_count    (match_count),
		.status         (back_status)
	);

	// An idle back end takes a waiting request at once.
	`PFDC_ASSERT_IMP(a_idle_takes, q_valid && back_status.idle, q_ready, "idle back end stalled")
	// A new result only comes out of the finishing step.
	`PFDC_ASSERT_IMP(a_result_src, $rose(out_valid), $past(back_status.finishing),
		"result without finishing step")
	// The back end is never idle and finishing at the same time.
	`PFDC_ASSERT_NEVER(a_idle_and_fin, back_status.idle && back_status.finishing,
		"back end in two states")

endmodule

>>> bench/tb.sv
// Self-checking bench for the packet FIFO core with duplicate filter and range count.
// Depends on pfdc_pkg and packet_fifo_dedup_count_core; holds its own queue predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pfdc_pkg::*;

	localparam int unsigned Depth = 256;

	typedef struct {
		logic        ok;
		logic [15:0] src;
		logic [15:0] dst;
		logic [31:0] ts;
		logic [8:0]  cnt;
	} reply_t;

	// The scoreboard keeps a behavioral copy of the packet queue and the expected replies.
	class packet_queue_board;
		logic [15:0] held_src[$];
		logic [15:0] held_dst[$];
		logic [31:0] held_ts[$];
		int unsigned cap_limit;
		reply_t      pending[$];
		int          mismatches;

		function void clear();
			held_src.delete();
			held_dst.delete();
			held_ts.delete();
			cap_limit = 256;
			pending.delete();
			mismatches = 0;
		endfunction

		function void set_limit(logic [8:0] v);
			cap_limit = (v == 0) ? 1 : (v > Depth) ? Depth : v;
		endfunction

		function void note_request(op_t op, logic [15:0] s, logic [15:0] d, logic [31:0] t,
				logic [31:0] lo, logic [31:0] hi);
			reply_t r;
			int unsigned n;
			bit dup;
			r = '{1'b0, 16'd0, 16'd0, 32'd0, 9'd0};
			dup = 0;
			n = 0;
			case (op)
				OP_ADD: begin
					foreach (held_ts[i])
						if (held_src[i] == s && held_dst[i] == d && held_ts[i] == t)
							dup = 1;
					if (!dup) begin
						// A full queue only sheds its single oldest packet per add.
						if (held_ts.size() >= cap_limit && held_ts.size() > 0) begin
							held_src.delete(0);
							held_dst.delete(0);
							held_ts.delete(0);
						end
						held_src = {held_src, s};
						held_dst = {held_dst, d};
						held_ts = {held_ts, t};
						r.ok = 1'b1;
					end
				end
				OP_FWD: begin
					if (held_ts.size() > 0) begin
						r.ok = 1'b1;
						r.src = held_src[0];
						r.dst = held_dst[0];
						r.ts = held_ts[0];
						held_src.delete(0);
						held_dst.delete(0);
						held_ts.delete(0);
					end
				end
				OP_CNT: begin
					foreach (held_ts[i])
						if (held_dst[i] == d && held_ts[i] >= lo && held_ts[i] <= hi)
							n++;
					r.cnt = (n > 511) ? 9'd511 : n[8:0];
				end
				default: ;
			endcase
			pending = {pending, r};
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reply ok=%0d src=%h dst=%h ts=%h cnt=%0d",
						got.ok, got.src, got.dst, got.ts, got.cnt);
				return;
			end
			want = pending[0];
			pending.delete(0);
			if (got.ok !== want.ok || got.src !== want.src || got.dst !== want.dst ||
					got.ts !== want.ts || got.cnt !== want.cnt) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"reply mismatch: exp ok=%0d src=%h dst=%h ts=%h cnt=%0d, ",
						"got ok=%0d src=%h dst=%h ts=%h cnt=%0d"},
						want.ok, want.src, want.dst, want.ts, want.cnt,
						got.ok, got.src, got.dst, got.ts, got.cnt);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [8:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [15:0] source;
	logic [15:0] destination;
	logic [31:0] timestamp;
	logic [31:0] range_start;
	logic [31:0] range_end;
	logic        out_valid;
	logic        out_ready;
	logic        ok;
	logic [15:0] out_source;
	logic [15:0] out_destination;
	logic [31:0] out_timestamp;
	logic [8:0]  match_count;

	packet_queue_board board;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	longint      cycle_count;
	logic [31:0] time_base;

	packet_fifo_dedup_count_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .source(source), .destination(destination),
		.timestamp(timestamp), .range_start(range_start), .range_end(range_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.ok(ok), .out_source(out_source), .out_destination(out_destination),
		.out_timestamp(out_timestamp), .match_count(match_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Every result is sampled at the edge where the handshake completes; the ready for
	// the next cycle is then redrawn from the current stall percentage.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_reply('{ok, out_source, out_destination, out_timestamp, match_count});
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// The watchdog covers the slowest correct run with a wide margin, allowing for the scan of
	// the held packets in each request and for stalls on both sides.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("tb failed");
			$finish;
		end
	end

	// Presents one request and holds it until the core takes it. The predictor is
	// updated at acceptance, so the expected reply order follows the request order.
	// Valid stays high afterwards so that the next request can follow at once.
	task automatic send_request(op_t op, logic [15:0] s, logic [15:0] d, logic [31:0] t,
			logic [31:0] lo, logic [31:0] hi);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= op;
		source <= s;
		destination <= d;
		timestamp <= t;
		range_start <= lo;
		range_end <= hi;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_request(op, s, d, t, lo, hi);
	endtask

	// Withdraws the input, waits for every reply, then lets the back end settle before
	// a register write.
	task automatic drain_replies();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_limit(logic [8:0] v);
		drain_replies();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_limit(v);
	endtask

	// Random traffic. Timestamps mostly climb slowly so that counts, duplicates and
	// ranges hit live packets; a small id pool makes duplicates and matches common.
	task automatic random_burst(int unsigned items);
		int unsigned pick;
		int unsigned k;
		logic [15:0] s;
		logic [15:0] d;
		logic [31:0] t;
		logic [31:0] lo;
		logic [31:0] hi;
		op_t         op;
		for (k = 0; k < items; k++) begin
			pick = $urandom_range(99);
			op = (pick < 50) ? OP_ADD : (pick < 72) ? OP_FWD : (pick < 97) ? OP_CNT : OP_NOP;
			if ($urandom_range(9) == 0) begin
				s = 16'($urandom);
				d = 16'($urandom);
			end else begin
				s = 16'($urandom_range(3));
				d = 16'($urandom_range(3));
			end
			if ($urandom_range(3) != 0)
				time_base += $urandom_range(2);
			t = ($urandom_range(19) == 0) ? $urandom : time_base;
			if ($urandom_range(9) == 0) begin
				lo = $urandom;
				hi = $urandom;
			end else begin
				lo = time_base - $urandom_range(8);
				hi = time_base + $urandom_range(4) - 2;
			end
			send_request(op, s, d, t, lo, hi);
		end
	endtask

	initial begin
		board = new();
		board.clear();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		command = OP_NOP;
		source = '0;
		destination = '0;
		timestamp = '0;
		range_start = '0;
		range_end = '0;
		out_ready = 1'b0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		time_base = 32'd100;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty forward and count, field extremes, duplicate rejection,
		// full-range and empty-range counts, unknown command, then pop back to empty.
		send_request(OP_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
		send_request(OP_CNT, 16'h0, 16'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_request(OP_ADD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
		send_request(OP_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		send_request(OP_ADD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
		send_request(OP_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_request(OP_ADD, 16'h5A5A, 16'hFFFF, 32'hA5A5_A5A5, 32'h0, 32'h0);
		send_request(OP_CNT, 16'h0, 16'hFFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_request(OP_CNT, 16'hFFFF, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_CNT, 16'h0, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
		send_request(OP_NOP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
		send_request(OP_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
		send_request(OP_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
		send_request(OP_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);

		// Limit of one: every accepted add replaces the sole packet.
		write_limit(9'd1);
		random_burst(60);
		// Zero acts as one; an oversized value acts as the full depth.
		write_limit(9'd0);
		send_idle_pct = 50;
		random_burst(60);
		write_limit(9'd511);
		send_idle_pct = 0;
		recv_stall_pct = 50;
		random_burst(150);
		// Lowering the limit under the current fill keeps the fill on later adds.
		write_limit(9'd3);
		send_idle_pct = 14;
		recv_stall_pct = 14;
		random_burst(120);
		write_limit(9'd256);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_burst(300);
		write_limit(9'd17);
		send_idle_pct = 50;
		recv_stall_pct = 50;
		random_burst(150);

		drain_replies();
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
